### sv/julian_day_ms_converter_core_assert.svh
// Assertion macros used by the top level of the Julian day millisecond converter.
`ifndef JULIAN_DAY_MS_CONVERTER_CORE_ASSERT_SVH
`define JULIAN_DAY_MS_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle, disabled while reset is held.
`define JDMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jdms assertion failed");
// Implication checked in the cycle after the antecedent, disabled while reset is held.
`define JDMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jdms assertion failed");
`else
`define JDMS_ASSERT_IMP(lbl, ante, cons)
`define JDMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/jdms_pkg.sv
// Package with the shared types, constants and tables of the Julian day converter.
`default_nettype none
package jdms_pkg;

  // Cycles from an accepted transaction to its result strobe.
  localparam int LAT = 12;

  // Time constants in milliseconds.
  localparam logic [25:0] HALF_DAY_MS = 26'd43200000;
  localparam logic [26:0] DAY_MS      = 27'd86400000;
  // The odd factor of one day: DAY_MS is this value times 1024.
  localparam logic [16:0] DAY_MS_ODD  = 17'd84375;

  // Reciprocals for division by constants. Ceiling reciprocals give exact
  // quotients over the operand ranges they are used on.
  localparam logic [23:0] R_DAY  = 24'((64'd1 << 40) / 64'd84375);
  localparam logic [25:0] R_A    = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [28:0] R_C    = 29'(((64'd1 << 41) + 64'd7304) / 64'd7305);
  localparam logic [24:0] R_E    = 25'((((64'd1 << 29) * 64'd10000) + 64'd306000)
                                       / 64'd306001);
  localparam logic [27:0] R_MIN  = 28'(((64'd1 << 43) + 64'd59999) / 64'd60000);
  localparam logic [11:0] R_HOUR = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
  localparam logic [12:0] R_Y100 = 13'd5243;

  // Civil date and time of one op 0 transaction.
  typedef struct packed {
    logic               date_valid;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               time_valid;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [15:0]        sec_ms;
    logic               zone_valid;
    logic signed [10:0] zone_minutes;
  } civil_in_t;

  // Civil date and time produced by an op 1 transaction.
  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [15:0]        sec_ms;
  } civil_out_t;

  // Whole days in idx months of 30.6001 days.
  function automatic logic [8:0] month_span(input logic [4:0] idx);
    logic [8:0] span;
    case (idx)
      5'd0:    span = 9'd0;
      5'd1:    span = 9'd30;
      5'd2:    span = 9'd61;
      5'd3:    span = 9'd91;
      5'd4:    span = 9'd122;
      5'd5:    span = 9'd153;
      5'd6:    span = 9'd183;
      5'd7:    span = 9'd214;
      5'd8:    span = 9'd244;
      5'd9:    span = 9'd275;
      5'd10:   span = 9'd306;
      5'd11:   span = 9'd336;
      5'd12:   span = 9'd367;
      5'd13:   span = 9'd397;
      5'd14:   span = 9'd428;
      5'd15:   span = 9'd459;
      5'd16:   span = 9'd489;
      default: span = 9'd0;
    endcase
    return span;
  endfunction

endpackage
`default_nettype wire

### sv/jdms_date_to_jd.sv
// Pipeline that turns a civil date and time into a Julian count in milliseconds.
`default_nettype none
module jdms_date_to_jd (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire jdms_pkg::civil_in_t civ,
  output logic                     out_valid,
  output logic [48:0]              jd
);

  localparam int PAD = jdms_pkg::LAT - 6;

  // Valid bits of the six working stages and of the padding line.
  logic [5:0]     vld;
  logic [PAD-1:0] pad_vld;
  logic [48:0]    pad_jd [PAD];

  // Stage 1 registers: defaulted and month-adjusted date, raw time fields.
  logic signed [14:0] t1_yadj;
  logic [4:0]         t1_midx;
  logic [4:0]         t1_day;
  logic [4:0]         t1_hour;
  logic [5:0]         t1_minute;
  logic [15:0]        t1_sec;
  logic               t1_tv;
  logic               t1_zv;
  logic signed [10:0] t1_zone;

  // Stage 2 registers.
  logic [7:0]         t2_a;
  logic [14:0]        t2_v;
  logic [8:0]         t2_x2;
  logic [4:0]         t2_day;
  logic [26:0]        t2_hms;
  logic [21:0]        t2_mms;
  logic [15:0]        t2_sec;
  logic signed [27:0] t2_zms;
  logic               t2_tv;
  logic               t2_zv;

  // Stage 3 to 6 registers.
  logic [9:0]  t3_b;
  logic [22:0] t3_x1;
  logic [8:0]  t3_x2;
  logic [4:0]  t3_day;
  logic [28:0] t3_tsum;
  logic [22:0] t4_dc;
  logic [28:0] t4_tsum;
  logic [48:0] t5_ms;
  logic [28:0] t5_tsum;
  logic [48:0] t6_jd;

  // Combinational values.
  logic [13:0]        ysel;
  logic [3:0]         msel;
  logic [4:0]         dsel;
  logic signed [14:0] yadj;
  logic [4:0]         midx;
  logic [26:0]        yprod;
  logic [24:0]        x1prod;
  logic [28:0]        tpos;
  logic [24:0]        dcsum;
  logic [49:0]        msprod;

  // Default the date and move January and February to the end of the year before.
  always_comb begin
    ysel = civ.date_valid ? civ.year  : 14'd2000;
    msel = civ.date_valid ? civ.month : 4'd1;
    dsel = civ.date_valid ? civ.day   : 5'd1;
    if (msel <= 4'd2) begin
      yadj = $signed({1'b0, ysel}) - 15'sd1;
      midx = 5'({1'b0, msel}) + 5'd13;
    end else begin
      yadj = $signed({1'b0, ysel});
      midx = 5'({1'b0, msel}) + 5'd1;
    end
  end

  // Century count by reciprocal, year term and time products.
  assign yprod  = 27'(t1_yadj[13:0]) * 27'(jdms_pkg::R_Y100);
  assign x1prod = 25'(t2_v) * 25'd1461;
  assign tpos   = 29'(t2_hms) + 29'(t2_mms) + 29'(t2_sec);
  assign dcsum  = 25'(t3_x1) + 25'(t3_x2) + 25'(t3_day) + {{15{t3_b[9]}}, t3_b}
                - 25'd1524;
  assign msprod = 50'(t4_dc) * 50'(jdms_pkg::DAY_MS);

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      pad_vld <= '0;
    end else begin
      vld     <= {vld[4:0], in_valid};
      pad_vld <= PAD'({pad_vld, vld[5]});
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    t1_yadj   <= yadj;
    t1_midx   <= midx;
    t1_day    <= dsel;
    t1_hour   <= civ.hour;
    t1_minute <= civ.minute;
    t1_sec    <= civ.sec_ms;
    t1_tv     <= civ.time_valid;
    t1_zv     <= civ.time_valid & civ.zone_valid;
    t1_zone   <= civ.zone_minutes;

    t2_a   <= t1_yadj[14] ? 8'd0 : yprod[26:19];
    t2_v   <= 15'(t1_yadj + 15'sd4716);
    t2_x2  <= jdms_pkg::month_span(t1_midx);
    t2_day <= t1_day;
    t2_hms <= 27'(t1_hour) * 27'd3600000;
    t2_mms <= 22'(t1_minute) * 22'd60000;
    t2_sec <= t1_sec;
    t2_zms <= 28'(t1_zone) * 28'sd60000;
    t2_tv  <= t1_tv;
    t2_zv  <= t1_zv;

    t3_b    <= 10'd2 - 10'(t2_a) + 10'(t2_a[7:2]);
    t3_x1   <= x1prod[24:2];
    t3_x2   <= t2_x2;
    t3_day  <= t2_day;
    t3_tsum <= t2_tv ? (tpos - (t2_zv ? 29'(t2_zms) : 29'd0)) : 29'd0;

    t4_dc   <= dcsum[22:0];
    t4_tsum <= t3_tsum;

    t5_ms   <= msprod[48:0];
    t5_tsum <= t4_tsum;

    t6_jd <= t5_ms - 49'(jdms_pkg::HALF_DAY_MS) + {{20{t5_tsum[28]}}, t5_tsum};
  end

  // Delay line that aligns this path with the reverse conversion.
  always_ff @(posedge clk) begin
    pad_jd[0] <= t6_jd;
    for (int i = 1; i < PAD; i++) begin
      pad_jd[i] <= pad_jd[i-1];
    end
  end

  assign out_valid = pad_vld[PAD-1];
  assign jd        = pad_jd[PAD-1];

endmodule
`default_nettype wire

### sv/jdms_jd_to_date.sv
// Pipeline that turns a Julian count in milliseconds into a civil date and time.
`default_nettype none
module jdms_jd_to_date (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [48:0]   jd_in,
  output logic               out_valid,
  output jdms_pkg::civil_out_t civ
);

  // Time of day fields carried down the pipeline.
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] sec_ms;
  } tod_t;

  logic [jdms_pkg::LAT-1:0] vld;

  // Day split registers.
  logic [39:0] s1_n;
  logic [9:0]  s1_lo;
  logic [23:0] s2_q;
  logic [39:0] s2_n;
  logic [9:0]  s2_lo;
  logic [40:0] s3_prod;
  logic [23:0] s3_q;
  logic [39:0] s3_n;
  logic [9:0]  s3_lo;
  logic [22:0] s4_z;
  logic [26:0] s4_tod;

  // Calendar registers.
  logic [24:0] s5_mag;
  logic        s5_neg;
  logic [22:0] s5_z;
  logic [7:0]  s6_a1q;
  logic        s6_neg;
  logic [22:0] s6_z;
  logic [22:0] s7_b;
  logic [27:0] s8_cnum;
  logic [22:0] s8_b;
  logic [14:0] s9_c;
  logic [22:0] s9_b;
  logic [14:0] s10_c;
  logic [9:0]  s10_bd;
  logic [14:0] s11_c;
  logic [9:0]  s11_bd;
  logic [4:0]  s11_e;
  jdms_pkg::civil_out_t s12;

  // Time of day registers.
  logic [26:0] s5_tod;
  logic [10:0] s5_tmin;
  logic [26:0] s6_tod;
  logic [10:0] s6_tmin;
  logic [4:0]  s6_hour;
  logic [26:0] s6_tm;
  tod_t        s7_t;
  tod_t        s8_t;
  tod_t        s9_t;
  tod_t        s10_t;
  tod_t        s11_t;

  // Combinational values.
  logic [49:0]        shifted;
  logic [47:0]        qprod;
  logic [40:0]        rdiff;
  logic [17:0]        r0;
  logic [23:0]        qfix;
  logic [16:0]        rfix;
  logic signed [25:0] anum;
  logic [54:0]        tminprod;
  logic [50:0]        aprod;
  logic [23:0]        hprod;
  logic signed [8:0]  a1;
  logic signed [8:0]  a1d4;
  logic [24:0]        bsum;
  logic [56:0]        cprod;
  logic [25:0]        dprod;
  logic [23:0]        bdw;
  logic [34:0]        eprod;
  logic [8:0]         x1;
  logic [4:0]         dom;
  logic [3:0]         mo;

  // Shift to midnight-based days and estimate the day count from the top bits.
  assign shifted = 50'(jd_in) + 50'(jdms_pkg::HALF_DAY_MS);
  assign qprod   = 48'(s1_n[39:16]) * 48'(jdms_pkg::R_DAY);

  // The estimate is at most two low; the remainder fixes it.
  assign rdiff = 41'(s3_n) - s3_prod;
  assign r0    = rdiff[17:0];
  always_comb begin
    if (r0 >= 18'(2 * jdms_pkg::DAY_MS_ODD)) begin
      qfix = s3_q + 24'd2;
      rfix = 17'(r0 - 18'(2 * jdms_pkg::DAY_MS_ODD));
    end else if (r0 >= 18'(jdms_pkg::DAY_MS_ODD)) begin
      qfix = s3_q + 24'd1;
      rfix = 17'(r0 - 18'(jdms_pkg::DAY_MS_ODD));
    end else begin
      qfix = s3_q;
      rfix = r0[16:0];
    end
  end

  // Gregorian century term, divided with truncation toward zero.
  assign anum     = $signed({1'b0, s4_z, 2'b00}) - 26'sd7468865;
  assign tminprod = 55'(s4_tod) * 55'(jdms_pkg::R_MIN);
  assign aprod    = 51'(s5_mag) * 51'(jdms_pkg::R_A);
  assign hprod    = 24'(s5_tmin) * 24'(jdms_pkg::R_HOUR);
  assign a1       = s6_neg ? -$signed({1'b0, s6_a1q}) : $signed({1'b0, s6_a1q});
  assign a1d4     = a1 / 9'sd4;
  assign bsum     = 25'(s6_z) + 25'd1525 + {{16{a1[8]}}, a1} - {{16{a1d4[8]}}, a1d4};

  // Year, day-of-year and month terms.
  assign cprod = 57'(s8_cnum) * 57'(jdms_pkg::R_C);
  assign dprod = 26'(s9_c) * 26'd1461;
  assign bdw   = 24'(s9_b) - dprod[25:2];
  assign eprod = 35'(s10_bd) * 35'(jdms_pkg::R_E);

  // Final month, day and year.
  assign x1  = jdms_pkg::month_span(s11_e);
  assign dom = 5'(s11_bd - 10'(x1));
  assign mo  = (s11_e < 5'd14) ? 4'(s11_e - 5'd1) : 4'(s11_e - 5'd13);

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[jdms_pkg::LAT-2:0], in_valid};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    s1_n  <= shifted[49:10];
    s1_lo <= shifted[9:0];

    s2_q  <= qprod[47:24];
    s2_n  <= s1_n;
    s2_lo <= s1_lo;

    s3_prod <= 41'(s2_q) * 41'(jdms_pkg::DAY_MS_ODD);
    s3_q    <= s2_q;
    s3_n    <= s2_n;
    s3_lo   <= s2_lo;

    s4_z   <= qfix[22:0];
    s4_tod <= {rfix, s3_lo};

    s5_neg  <= anum[25];
    s5_mag  <= anum[25] ? 25'(-anum) : anum[24:0];
    s5_z    <= s4_z;
    s5_tod  <= s4_tod;
    s5_tmin <= tminprod[53:43];

    s6_a1q  <= aprod[50:43];
    s6_neg  <= s5_neg;
    s6_z    <= s5_z;
    s6_tod  <= s5_tod;
    s6_tmin <= s5_tmin;
    s6_hour <= hprod[21:17];
    s6_tm   <= 27'(s5_tmin) * 27'd60000;

    s7_b           <= bsum[22:0];
    s7_t.hour      <= s6_hour;
    s7_t.minute    <= 6'(s6_tmin - 11'(s6_hour) * 11'd60);
    s7_t.sec_ms    <= 16'(s6_tod - s6_tm);

    s8_cnum <= 28'(s7_b) * 28'd20 - 28'd2442;
    s8_b    <= s7_b;
    s8_t    <= s7_t;

    s9_c <= cprod[55:41];
    s9_b <= s8_b;
    s9_t <= s8_t;

    s10_c  <= s9_c;
    s10_bd <= bdw[9:0];
    s10_t  <= s9_t;

    s11_c  <= s10_c;
    s11_bd <= s10_bd;
    s11_e  <= eprod[33:29];
    s11_t  <= s10_t;

    s12.year   <= (mo > 4'd2) ? (15'(s11_c) - 15'd4716) : (15'(s11_c) - 15'd4715);
    s12.month  <= mo;
    s12.day    <= dom;
    s12.hour   <= s11_t.hour;
    s12.minute <= s11_t.minute;
    s12.sec_ms <= s11_t.sec_ms;
  end

  assign out_valid = vld[jdms_pkg::LAT-1];
  assign civ       = s12;

endmodule
`default_nettype wire

### sv/julian_day_ms_converter_core.sv
// Top level of the Julian day millisecond converter.
`default_nettype none
`include "julian_day_ms_converter_core_assert.svh"
// Converts a civil date and time to a Julian day count in milliseconds (op 0)
// or a count back to a civil date and time (op 1). Both directions run in
// twelve-stage pipelines, so a transaction can start in every clock cycle
// outside of reset, and its result appears on the result ports, marked by
// done for one cycle. The latency is set by the longer reverse path: the day
// split by reciprocal multiply and correction, then the chain of calendar
// divisions, at most one multiply per stage. busy is high
// only while reset is held. The receiver cannot stall, and none is needed:
// results leave in the order the transactions came in, one per cycle at most.
// Fields that the chosen op does not produce read as zero.
module julian_day_ms_converter_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic               date_valid,
  input  wire logic [13:0]        year,
  input  wire logic [3:0]         month,
  input  wire logic [4:0]         day,
  input  wire logic               time_valid,
  input  wire logic [4:0]         hour,
  input  wire logic [5:0]         minute,
  input  wire logic [15:0]        sec_ms,
  input  wire logic               zone_valid,
  input  wire logic signed [10:0] zone_minutes,
  input  wire logic [48:0]        jd_in,
  output logic                    done,
  output logic [48:0]             jd_out,
  output logic signed [14:0]      year_out,
  output logic [3:0]              month_out,
  output logic [4:0]              day_out,
  output logic [4:0]              hour_out,
  output logic [5:0]              minute_out,
  output logic [15:0]             sec_ms_out
);

  logic                 accept;
  jdms_pkg::civil_in_t  civ_in;
  logic                 d2j_done;
  logic [48:0]          d2j_jd;
  logic                 j2d_done;
  jdms_pkg::civil_out_t j2d_civ;

  // The pipelines take a transaction every cycle outside of reset.
  assign busy   = rst;
  assign accept = start & ~busy;

  // Gather the op 0 fields.
  always_comb begin
    civ_in.date_valid   = date_valid;
    civ_in.year         = year;
    civ_in.month        = month;
    civ_in.day          = day;
    civ_in.time_valid   = time_valid;
    civ_in.hour         = hour;
    civ_in.minute       = minute;
    civ_in.sec_ms       = sec_ms;
    civ_in.zone_valid   = zone_valid;
    civ_in.zone_minutes = zone_minutes;
  end

  jdms_date_to_jd u_date_to_jd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept & ~op),
    .civ       (civ_in),
    .out_valid (d2j_done),
    .jd        (d2j_jd)
  );

  jdms_jd_to_date u_jd_to_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept & op),
    .jd_in     (jd_in),
    .out_valid (j2d_done),
    .civ       (j2d_civ)
  );

  // Merge the two paths; the fields of the other direction read as zero.
  assign done       = d2j_done | j2d_done;
  assign jd_out     = d2j_done ? d2j_jd : 49'd0;
  assign year_out   = j2d_done ? j2d_civ.year : 15'sd0;
  assign month_out  = j2d_done ? j2d_civ.month : 4'd0;
  assign day_out    = j2d_done ? j2d_civ.day : 5'd0;
  assign hour_out   = j2d_done ? j2d_civ.hour : 5'd0;
  assign minute_out = j2d_done ? j2d_civ.minute : 6'd0;
  assign sec_ms_out = j2d_done ? j2d_civ.sec_ms : 16'd0;

  // Every accepted transaction is followed by its result strobe.
  `JDMS_ASSERT_IMP(a_latency, accept, ##(jdms_pkg::LAT) done)
  // A strobe only follows an accepted transaction.
  `JDMS_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, jdms_pkg::LAT))
  // The two paths never finish in the same cycle.
  `JDMS_ASSERT_IMP(a_paths_exclusive, d2j_done, !j2d_done)

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the Julian day millisecond converter core.
module testbench;

  // Operation codes carried on the op port.
  localparam bit OP_TO_COUNT = 1'b0;
  localparam bit OP_TO_CIVIL = 1'b1;

  // Millisecond constants of the calendar arithmetic.
  localparam longint MS_HALF_DAY = 43200000;
  localparam longint MS_PER_DAY  = 86400000;
  localparam longint MS_PER_HOUR = 3600000;
  localparam longint MS_PER_MIN  = 60000;
  localparam longint JD_IN_MAX   = 64'd464269060799999;

  localparam int ITEM_COUNT  = 1950;
  localparam int CYCLE_LIMIT = 200000;

  // One conversion request and the result it produces.
  typedef struct packed {
    logic                 op;
    jdms_pkg::civil_in_t  civil;
    logic [48:0]          jd_in;
  } conv_req_t;

  typedef struct packed {
    logic [48:0]          jd;
    jdms_pkg::civil_out_t civil;
  } conv_res_t;

  // A directed row; typed rows carry a hand-written expectation.
  typedef struct {
    conv_req_t req;
    bit        typed;
    conv_res_t want;
  } vector_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               op = 1'b0;
  logic               date_valid = 1'b0;
  logic [13:0]        year = '0;
  logic [3:0]         month = '0;
  logic [4:0]         day = '0;
  logic               time_valid = 1'b0;
  logic [4:0]         hour = '0;
  logic [5:0]         minute = '0;
  logic [15:0]        sec_ms = '0;
  logic               zone_valid = 1'b0;
  logic signed [10:0] zone_minutes = '0;
  logic [48:0]        jd_in = '0;
  logic               busy;
  logic               done;
  logic [48:0]        jd_out;
  logic signed [14:0] year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic [4:0]         hour_out;
  logic [5:0]         minute_out;
  logic [15:0]        sec_ms_out;

  conv_res_t predicted_conversions[$];
  int        sender_idle_pct = 0;
  int        mismatches = 0;
  int        conversions_checked = 0;
  int        to_count_sent = 0;
  int        to_civil_sent = 0;
  int        cycle_count = 0;

  julian_day_ms_converter_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .date_valid   (date_valid),
    .year         (year),
    .month        (month),
    .day          (day),
    .time_valid   (time_valid),
    .hour         (hour),
    .minute       (minute),
    .sec_ms       (sec_ms),
    .zone_valid   (zone_valid),
    .zone_minutes (zone_minutes),
    .jd_in        (jd_in),
    .done         (done),
    .jd_out       (jd_out),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_out      (day_out),
    .hour_out     (hour_out),
    .minute_out   (minute_out),
    .sec_ms_out   (sec_ms_out)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Civil date and time to millisecond count, all quotients cut toward zero.
  function automatic logic [48:0] count_from_civil(jdms_pkg::civil_in_t c);
    longint yr, mo, dd, cent, greg, ms;
    yr = 2000;
    mo = 1;
    dd = 1;
    if (c.date_valid) begin
      yr = longint'(c.year);
      mo = longint'(c.month);
      dd = longint'(c.day);
    end
    // January and February count as months 13 and 14 of the year before.
    if (mo <= 2) begin
      yr -= 1;
      mo += 12;
    end
    cent = yr / 100;
    greg = 2 - cent + cent / 4;
    ms = (36525 * (yr + 4716) / 100 + 306001 * (mo + 1) / 10000 + dd + greg - 1524)
         * MS_PER_DAY - MS_HALF_DAY;
    if (c.time_valid) begin
      ms += longint'(c.hour) * MS_PER_HOUR + longint'(c.minute) * MS_PER_MIN
            + longint'(c.sec_ms);
      if (c.zone_valid) begin
        ms -= longint'(c.zone_minutes) * MS_PER_MIN;
      end
    end
    return ms[48:0];
  endfunction

  // Millisecond count back to civil date and time.
  function automatic jdms_pkg::civil_out_t civil_from_count(logic [48:0] jd);
    jdms_pkg::civil_out_t o;
    longint shifted, tod, z, alpha, b, c, d, e, dom, mo, yr;
    shifted = longint'(jd) + MS_HALF_DAY;
    tod = shifted % MS_PER_DAY;
    z = shifted / MS_PER_DAY;
    alpha = (4 * z - 7468865) / 146097;
    alpha = z + 1 + alpha - alpha / 4;
    b = alpha + 1524;
    c = (20 * b - 2442) / 7305;
    d = 36525 * c / 100;
    e = 10000 * (b - d) / 306001;
    dom = b - d - 306001 * e / 10000;
    mo = (e < 14) ? e - 1 : e - 13;
    yr = (mo > 2) ? c - 4716 : c - 4715;
    o.year = 15'(yr);
    o.month = 4'(mo);
    o.day = 5'(dom);
    o.hour = 5'(tod / MS_PER_HOUR);
    o.minute = 6'((tod / MS_PER_MIN) % 60);
    o.sec_ms = 16'(tod % MS_PER_MIN);
    return o;
  endfunction

  // Expected result of one request; fields the op does not produce stay zero.
  function automatic conv_res_t convert_timestamp(conv_req_t r);
    conv_res_t res;
    res = '0;
    if (r.op == OP_TO_COUNT) begin
      res.jd = count_from_civil(r.civil);
    end else begin
      res.civil = civil_from_count(r.jd_in);
    end
    return res;
  endfunction

  // Random civil fields inside their ranges, with weight on notable years.
  function automatic jdms_pkg::civil_in_t random_civil();
    jdms_pkg::civil_in_t c;
    c.date_valid = ($urandom_range(9) != 0);
    case ($urandom_range(15))
      0: c.year = 14'd0;
      1: c.year = 14'd9999;
      2: c.year = 14'd1600;
      3: c.year = 14'd1900;
      4: c.year = 14'd8192;
      default: c.year = 14'($urandom_range(9999));
    endcase
    c.month = 4'($urandom_range(12, 1));
    c.day = 5'($urandom_range(31, 1));
    c.time_valid = ($urandom_range(4) != 0);
    c.hour = 5'($urandom_range(24));
    c.minute = 6'($urandom_range(59));
    c.sec_ms = 16'($urandom_range(59999));
    c.zone_valid = 1'($urandom_range(1));
    c.zone_minutes = 11'(int'($urandom_range(1798)) - 899);
    return c;
  endfunction

  // Random count: day boundaries, the first days, or anywhere in range.
  function automatic logic [48:0] random_count();
    longint unsigned jd;
    case ($urandom_range(3))
      0: jd = longint'($urandom_range(5373483, 1)) * MS_PER_DAY + MS_HALF_DAY - 2
              + $urandom_range(3);
      1: jd = {$urandom, $urandom} % 64'd4000000000;
      default: jd = {$urandom, $urandom} % (JD_IN_MAX + 1);
    endcase
    return jd[48:0];
  endfunction

  // Date request with the given fields; the unused count is random.
  function automatic conv_req_t civil_request(int dv, int yr, int mo, int dd, int tv,
                                              int hh, int mi, int ss, int zv, int zone);
    conv_req_t r;
    r.op = OP_TO_COUNT;
    r.civil = '{date_valid: dv[0], year: 14'(yr), month: 4'(mo), day: 5'(dd),
                time_valid: tv[0], hour: 5'(hh), minute: 6'(mi), sec_ms: 16'(ss),
                zone_valid: zv[0], zone_minutes: 11'(zone)};
    r.jd_in = random_count();
    return r;
  endfunction

  // Count request; the unused civil fields are random.
  function automatic conv_req_t count_request(longint unsigned jd);
    conv_req_t r;
    r.op = OP_TO_CIVIL;
    r.civil = random_civil();
    r.jd_in = jd[48:0];
    return r;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t r;
    r.op = 1'($urandom_range(1));
    r.civil = random_civil();
    r.jd_in = random_count();
    return r;
  endfunction

  // Report one field that differs from its expectation.
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Drive one transaction after a random idle gap and wait until it is taken.
  task automatic send_conversion(input conv_req_t r, input bit typed, input conv_res_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    date_valid <= r.civil.date_valid;
    year <= r.civil.year;
    month <= r.civil.month;
    day <= r.civil.day;
    time_valid <= r.civil.time_valid;
    hour <= r.civil.hour;
    minute <= r.civil.minute;
    sec_ms <= r.civil.sec_ms;
    zone_valid <= r.civil.zone_valid;
    zone_minutes <= r.civil.zone_minutes;
    jd_in <= r.jd_in;
    do @(posedge clk); while (busy);
    predicted_conversions.push_back(typed ? want : convert_timestamp(r));
    if (r.op == OP_TO_COUNT) to_count_sent++;
    else to_civil_sent++;
  endtask

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk) begin : result_check
    conv_res_t got, want;
    if (!rst && done) begin
      got = '{jd: jd_out, civil: '{year: year_out, month: month_out, day: day_out,
                                   hour: hour_out, minute: minute_out, sec_ms: sec_ms_out}};
      if (predicted_conversions.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, got jd_out %0d",
                 $time, got.jd);
      end else begin
        want = predicted_conversions.pop_front();
        check_field("jd_out", longint'(want.jd), longint'(got.jd));
        check_field("year_out", longint'(want.civil.year), longint'(got.civil.year));
        check_field("month_out", longint'(want.civil.month), longint'(got.civil.month));
        check_field("day_out", longint'(want.civil.day), longint'(got.civil.day));
        check_field("hour_out", longint'(want.civil.hour), longint'(got.civil.hour));
        check_field("minute_out", longint'(want.civil.minute), longint'(got.civil.minute));
        check_field("sec_ms_out", longint'(want.civil.sec_ms), longint'(got.civil.sec_ms));
        conversions_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    vector_row_t vectors[$];
    int random_items;

    // Defaults with time and zone ignored give 2000-01-01 at midnight.
    vectors.push_back('{req: civil_request(0, 9999, 12, 31, 0, 24, 59, 59999, 1, -899),
                        typed: 1'b1, want: '{jd: 49'd211813444800000, civil: '0}});
    // Noon on the same day; the zone is off.
    vectors.push_back('{req: civil_request(1, 2000, 1, 1, 1, 12, 0, 0, 0, 899),
                        typed: 1'b1, want: '{jd: 49'd211813488000000, civil: '0}});
    // Count zero is noon of the first day of the count.
    vectors.push_back('{req: count_request(64'd0), typed: 1'b1,
                        want: '{jd: '0, civil: '{year: -4713, month: 11, day: 24,
                                                 hour: 12, minute: 0, sec_ms: 0}}});
    vectors.push_back('{req: count_request(64'd211813444800000), typed: 1'b1,
                        want: '{jd: '0, civil: '{year: 2000, month: 1, day: 1,
                                                 hour: 0, minute: 0, sec_ms: 0}}});
    // Largest count, midnight boundaries and the top bit.
    vectors.push_back('{req: count_request(JD_IN_MAX), typed: 1'b0, want: '0});
    vectors.push_back('{req: count_request(64'd43199999), typed: 1'b0, want: '0});
    vectors.push_back('{req: count_request(64'd43200000), typed: 1'b0, want: '0});
    vectors.push_back('{req: count_request(64'd211813444799999), typed: 1'b0, want: '0});
    vectors.push_back('{req: count_request(64'd1 << 48), typed: 1'b0, want: '0});
    vectors.push_back('{req: count_request(2000 * MS_PER_DAY), typed: 1'b0, want: '0});
    // Earliest date with the zone pushing the count back.
    vectors.push_back('{req: civil_request(1, 0, 1, 1, 1, 0, 0, 0, 1, 899),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 0, 2, 29, 0, 5, 5, 5, 0, 0),
                        typed: 1'b0, want: '0});
    // Largest fields everywhere with the zone adding time.
    vectors.push_back('{req: civil_request(1, 9999, 12, 31, 1, 24, 59, 59999, 1, -899),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 1582, 10, 4, 1, 23, 59, 59999, 0, 0),
                        typed: 1'b0, want: '0});
    // A day that does not exist still goes through the formulas.
    vectors.push_back('{req: civil_request(1, 1900, 2, 29, 1, 6, 30, 1500, 1, -300),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 2000, 2, 29, 1, 18, 45, 30250, 1, 330),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 1999, 12, 31, 1, 23, 59, 59999, 1, 60),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 8191, 7, 15, 1, 16, 32, 32768, 1, -1),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 8192, 8, 16, 1, 15, 31, 32767, 1, 512),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 100, 3, 1, 0, 0, 0, 0, 1, 1),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 1, 2, 28, 1, 0, 0, 1, 1, -512),
                        typed: 1'b0, want: '0});
    vectors.push_back('{req: civil_request(1, 2024, 3, 1, 1, 0, 0, 0, 1, 0),
                        typed: 1'b0, want: '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 9;
    foreach (vectors[i]) begin
      send_conversion(vectors[i].req, vectors[i].typed, vectors[i].want);
    end

    // Three random phases: light sender gaps, heavy gaps, then back to back.
    // The sender holds off between phases until every result is back.
    random_items = (ITEM_COUNT - vectors.size()) / 3;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 57 : 0;
      repeat (random_items) send_conversion(random_request(), 1'b0, '0);
      start <= 1'b0;
      do @(posedge clk); while (predicted_conversions.size() != 0);
    end

    // Catch any stray result after the last one.
    repeat (jdms_pkg::LAT + 4) @(posedge clk);

    $display("Sent %0d date-to-count and %0d count-to-date transactions.",
             to_count_sent, to_civil_sent);
    $display("Checked %0d results field by field, %0d field errors.",
             conversions_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/jdms_pkg.sv
sv/jdms_date_to_jd.sv
sv/jdms_jd_to_date.sv
sv/julian_day_ms_converter_core.sv
bench/testbench.sv
